// File: rtl/bbel_pkg.sv
// Shared types, widths and constants for the Bethe-Bloch energy loss pipeline.
package bbel_pkg;

	localparam int ENERGY_BITS = 24;
	localparam int X_W = 2 * ENERGY_BITS + 2;
	localparam int E_W = $clog2(X_W);
	localparam int LN_W = E_W + 32;
	localparam int N_ITER = 32;
	localparam int LN_LAT = 2 * N_ITER + 4;
	localparam int CFG_W = 24;
	localparam int P_W = 67;
	localparam int DK_W = 38;

	localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;
	localparam logic [9:0] ME_KEV = 10'd511;
	localparam logic [10:0] ME2_KEV = 11'd1022;
	localparam logic [18:0] K_MICRO = 19'd307075;
	localparam logic [DK_W-1:0] DEN_K = 38'd131072000000;

	localparam logic [1:0] REG_EXC = 2'd0;
	localparam logic [1:0] REG_ZOA = 2'd1;
	localparam logic [1:0] REG_RHO = 2'd2;
	localparam logic [1:0] REG_CHG = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_NEG = 2'd2;
	localparam logic [1:0] ST_SAT = 2'd3;

	typedef struct packed {
		logic [ENERGY_BITS-1:0] kinetic_energy;
		logic [ENERGY_BITS-1:0] particle_mass;
	} item_t;

	typedef struct packed {
		logic [31:0] energy_loss;
		logic [1:0] status;
	} result_t;

	function automatic logic [63:0] ln_q32_const(input logic [63:0] x);
		logic [6:0] e;
		logic [63:0] m;
		logic [63:0] frac;
		logic [63:0] l2;
		logic [127:0] sq;
		logic [127:0] pr;
		e = '0;
		for (int i = 0; i < 64; i++) begin
			if (x[i]) e = 7'(i);
		end
		m = x << (7'd63 - e);
		frac = '0;
		for (int i = 0; i < 32; i++) begin
			sq = {64'd0, m} * {64'd0, m};
			frac = {frac[62:0], sq[127]};
			m = sq[127] ? sq[127:64] : sq[126:63];
		end
		l2 = {25'd0, e, 32'd0} | frac;
		pr = {64'd0, l2} * {64'd0, LN2_Q64};
		return pr[127:64];
	endfunction

	// ln(2 me)^2 * 1e8 in Q32
	localparam logic [63:0] LN_K64 = ln_q32_const(64'd104448400000000);
	localparam logic [LN_W-1:0] LN_K = LN_K64[LN_W-1:0];

endpackage

// File: rtl/bbel_ln.sv
// Pipelined natural log in Q32 by repeated squaring of a normalized mantissa.
module bbel_ln (
	input  logic                       clk,
	input  logic                       en,
	input  logic [bbel_pkg::X_W-1:0]   x,
	output logic [bbel_pkg::LN_W-1:0]  ln
);
	localparam int X_W = bbel_pkg::X_W;
	localparam int E_W = bbel_pkg::E_W;
	localparam int LN_W = bbel_pkg::LN_W;
	localparam int NI = bbel_pkg::N_ITER;

	logic [X_W-1:0] x_s1;
	logic [E_W-1:0] e_s1;
	logic [E_W-1:0] e_c;
	logic [X_W+63:0] zw;

	logic [63:0] m_s [0:NI];
	logic [E_W-1:0] e_s [0:NI];
	logic [31:0] f_s [0:NI];
	logic [63:0] ll_s [0:NI-1];
	logic [63:0] lh_s [0:NI-1];
	logic [63:0] hh_s [0:NI-1];
	logic [E_W-1:0] ea_s [0:NI-1];
	logic [31:0] fa_s [0:NI-1];

	logic [LN_W-1:0] l2;
	logic [LN_W+31:0] p0_s;
	logic [LN_W+31:0] p1_s;
	logic [LN_W+63:0] sum;
	logic [LN_W-1:0] ln_s;

	always_comb begin
		e_c = '0;
		for (int i = 0; i < X_W; i++) begin
			if (x[i]) e_c = E_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x;
			e_s1 <= e_c;
		end
	end

	assign zw = {x_s1, 64'd0} << (E_W'(X_W - 1) - e_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0] <= zw[X_W+63 -: 64];
			e_s[0] <= e_s1;
			f_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < NI; i++) begin : g_it
		logic [127:0] full;

		always_ff @(posedge clk) begin
			if (en) begin
				ll_s[i] <= 64'(m_s[i][31:0]) * 64'(m_s[i][31:0]);
				lh_s[i] <= 64'(m_s[i][31:0]) * 64'(m_s[i][63:32]);
				hh_s[i] <= 64'(m_s[i][63:32]) * 64'(m_s[i][63:32]);
				ea_s[i] <= e_s[i];
				fa_s[i] <= f_s[i];
			end
		end

		assign full = {hh_s[i], ll_s[i]} + (128'(lh_s[i]) << 33);

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[i+1] <= full[127] ? full[127:64] : full[126:63];
				f_s[i+1] <= {fa_s[i][30:0], full[127]};
				e_s[i+1] <= ea_s[i];
			end
		end
	end

	assign l2 = {e_s[NI], f_s[NI]};

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s <= (LN_W + 32)'(l2) * (LN_W + 32)'(bbel_pkg::LN2_Q64[31:0]);
			p1_s <= (LN_W + 32)'(l2) * (LN_W + 32)'(bbel_pkg::LN2_Q64[63:32]);
		end
	end

	assign sum = (LN_W + 64)'(p0_s) + ((LN_W + 64)'(p1_s) << 32);

	always_ff @(posedge clk) begin
		if (en) begin
			ln_s <= sum[LN_W+63:64];
		end
	end

	assign ln = ln_s;

endmodule

// File: rtl/bethe_bloch_energy_loss.sv
// Top level: Bethe-Bloch mean energy loss pipeline with configuration registers.
// Throughput: one item per cycle; 32-step log iterations and two 32-step dividers set depth.
// A stalled result beat holds the whole pipeline and stalls the item channel.
// Reset clears all valid bits and loads the gas and charge registers with defaults.
module bethe_bloch_energy_loss (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  bbel_pkg::item_t          item,
	output logic                     result_valid,
	input  logic                     result_stall,
	output bbel_pkg::result_t        result,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [bbel_pkg::CFG_W-1:0] cfg_data
);
	localparam int EB = bbel_pkg::ENERGY_BITS;
	localparam int X_W = bbel_pkg::X_W;
	localparam int LN_W = bbel_pkg::LN_W;
	localparam int P_W = bbel_pkg::P_W;
	localparam int DK_W = bbel_pkg::DK_W;
	localparam int S_W = LN_W + 2;
	localparam int L_W = LN_W + 3;
	localparam int SC_W = S_W + X_W;
	localparam int PH_W = P_W - 32;
	localparam int L2_W = SC_W - 64;
	localparam int N_W = P_W + SC_W;
	localparam int D_W = X_W + DK_W;
	localparam int NN_W = N_W + 2;
	localparam int DD_W = D_W + 1;
	localparam int CMP_W = (NN_W > DD_W + 32) ? NN_W : DD_W + 32;

	localparam int ST_LN = 2 + bbel_pkg::LN_LAT;
	localparam int DV_END = 2 + 32;
	localparam int ST_L = ST_LN + 1;
	localparam int ST_S = ST_L + 1;
	localparam int ST_NUM = ST_S + 5;
	localparam int ST_R0 = ST_NUM + 2;
	localparam int NS = ST_R0 + 33;

	typedef struct packed {
		logic vld;
		logic zro;
		logic neg;
		logic sat;
	} flags_t;

	logic en;
	flags_t fl_s [1:NS];

	// configuration
	logic [15:0] exc_q;
	logic [15:0] zoa_q;
	logic [23:0] rho_q;
	logic [3:0] chg_q;
	logic [26:0] p1_q;
	logic [39:0] p2_q;
	logic [P_W-1:0] p_q;
	logic [7:0] zz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exc_q <= 16'd1674;
			zoa_q <= 16'd30147;
			rho_q <= 24'd1773;
			chg_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				bbel_pkg::REG_EXC: exc_q <= cfg_data[15:0];
				bbel_pkg::REG_ZOA: zoa_q <= cfg_data[15:0];
				bbel_pkg::REG_RHO: rho_q <= cfg_data[23:0];
				bbel_pkg::REG_CHG: chg_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign zz = 8'(chg_q) * 8'(chg_q);

	always_ff @(posedge clk) begin
		p1_q <= 27'(bbel_pkg::K_MICRO) * 27'(zz);
		p2_q <= 40'(zoa_q) * 40'(rho_q);
		p_q <= P_W'(p1_q) * P_W'(p2_q);
	end

	assign en = !(fl_s[NS].vld && result_stall);
	assign item_stall = !en;

	// flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_s[1] <= '0;
		end else if (en) begin
			fl_s[1] <= '{vld: item_valid,
				zro: (item.kinetic_energy == '0) || (item.particle_mass == '0),
				neg: 1'b0, sat: 1'b0};
		end
	end

	logic neg_c;
	logic sat_c;

	for (genvar k = 2; k <= NS; k++) begin : g_fl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fl_s[k] <= '0;
			end else if (en) begin
				fl_s[k] <= '{vld: fl_s[k-1].vld, zro: fl_s[k-1].zro,
					neg: (k == ST_S) ? neg_c : fl_s[k-1].neg,
					sat: (k == ST_R0) ? sat_c : fl_s[k-1].sat};
			end
		end
	end

	// stage 1
	logic [EB-1:0] t_s1;
	logic [EB-1:0] m_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= item.kinetic_energy;
			m_s1 <= item.particle_mass;
		end
	end

	// stage 2: a = T(T+2M), c = (T+M)^2, M^2, (M+me)^2 + 2 me T
	logic [EB:0] tm;
	logic [EB+1:0] t2m;
	logic [EB:0] mp;
	logic [X_W-1:0] a_s2;
	logic [X_W-1:0] msq_s2;
	logic [X_W-1:0] dt_s2;
	logic [X_W-1:0] c_s [2:ST_LN];
	logic [X_W-1:0] r_s [2:DV_END-1];
	logic [31:0] q_s [2:ST_LN];

	assign tm = (EB + 1)'(t_s1) + (EB + 1)'(m_s1);
	assign t2m = (EB + 2)'(t_s1) + ((EB + 2)'(m_s1) << 1);
	assign mp = (EB + 1)'(m_s1) + (EB + 1)'(bbel_pkg::ME_KEV);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= X_W'(t_s1) * X_W'(t2m);
			msq_s2 <= X_W'(m_s1) * X_W'(m_s1);
			dt_s2 <= X_W'(mp) * X_W'(mp) + X_W'(t_s1) * X_W'(bbel_pkg::ME2_KEV);
			c_s[2] <= X_W'(tm) * X_W'(tm);
			r_s[2] <= X_W'(t_s1) * X_W'(t2m);
			q_s[2] <= '0;
		end
	end

	// logarithms
	logic [15:0] exc1;
	logic [LN_W-1:0] ln_a;
	logic [LN_W-1:0] ln_m;
	logic [LN_W-1:0] ln_d;
	logic [LN_W-1:0] ln_i;

	assign exc1 = (exc_q == '0) ? 16'd1 : exc_q;

	bbel_ln u_ln_a (.clk(clk), .en(en), .x(a_s2), .ln(ln_a));
	bbel_ln u_ln_m (.clk(clk), .en(en), .x(msq_s2), .ln(ln_m));
	bbel_ln u_ln_d (.clk(clk), .en(en), .x(dt_s2), .ln(ln_d));
	bbel_ln u_ln_i (.clk(clk), .en(en), .x(X_W'(exc1)), .ln(ln_i));

	// beta^2 = a / c, one quotient bit per stage
	for (genvar k = 3; k <= ST_LN; k++) begin : g_b2
		if (k <= DV_END) begin : g_step
			logic [X_W:0] rr;
			logic ge;
			assign rr = {r_s[k-1], 1'b0};
			assign ge = rr >= {1'b0, c_s[k-1]};
			always_ff @(posedge clk) begin
				if (en) begin
					c_s[k] <= c_s[k-1];
					q_s[k] <= {q_s[k-1][30:0], ge};
				end
			end
			if (k < DV_END) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						r_s[k] <= ge ? X_W'(rr - {1'b0, c_s[k-1]}) : X_W'(rr);
					end
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					c_s[k] <= c_s[k-1];
					q_s[k] <= q_s[k-1];
				end
			end
		end
	end

	// denominator a * 2 * 65536 * 1e6
	logic [DK_W+31:0] pd0_s3;
	logic [X_W-32+DK_W-1:0] pd1_s3;
	logic [D_W-1:0] den_s [4:ST_NUM];

	always_ff @(posedge clk) begin
		if (en) begin
			pd0_s3 <= (DK_W + 32)'(a_s2[31:0]) * (DK_W + 32)'(bbel_pkg::DEN_K);
			pd1_s3 <= (X_W - 32 + DK_W)'(a_s2[X_W-1:32]) * (X_W - 32 + DK_W)'(bbel_pkg::DEN_K);
			den_s[4] <= D_W'(pd0_s3) + (D_W'(pd1_s3) << 32);
		end
	end

	for (genvar k = 5; k <= ST_NUM; k++) begin : g_den
		always_ff @(posedge clk) begin
			if (en) den_s[k] <= den_s[k-1];
		end
	end

	// bracket
	logic [L_W-1:0] l_s71;
	logic [31:0] b2_s71;
	logic [X_W-1:0] c_s71;
	logic [L_W-1:0] sv;
	logic [S_W-1:0] s_s72;
	logic [X_W-1:0] c_s72;

	always_ff @(posedge clk) begin
		if (en) begin
			l_s71 <= L_W'(bbel_pkg::LN_K) + (L_W'(ln_a) << 1) - L_W'(ln_m) - L_W'(ln_d)
				- (L_W'(ln_i) << 1);
			b2_s71 <= q_s[ST_LN];
			c_s71 <= c_s[ST_LN];
		end
	end

	assign sv = l_s71 - (L_W'(b2_s71) << 1);
	assign neg_c = sv[L_W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			s_s72 <= sv[S_W-1:0];
			c_s72 <= c_s71;
		end
	end

	// numerator P * s * c
	logic [S_W+31:0] psl_s73;
	logic [S_W+X_W-33:0] psh_s73;
	logic [SC_W-1:0] sc_s74;
	logic [63:0] pl0_s75;
	logic [63:0] pl1_s75;
	logic [L2_W+31:0] pl2_s75;
	logic [PH_W+31:0] ph0_s75;
	logic [PH_W+31:0] ph1_s75;
	logic [PH_W+L2_W-1:0] ph2_s75;
	logic [SC_W+31:0] rlo_s76;
	logic [SC_W+PH_W-1:0] rhi_s76;
	logic [N_W-1:0] num_s77;

	always_ff @(posedge clk) begin
		if (en) begin
			psl_s73 <= (S_W + 32)'(s_s72) * (S_W + 32)'(c_s72[31:0]);
			psh_s73 <= (S_W + X_W - 32)'(s_s72) * (S_W + X_W - 32)'(c_s72[X_W-1:32]);
			sc_s74 <= SC_W'(psl_s73) + (SC_W'(psh_s73) << 32);
			pl0_s75 <= 64'(p_q[31:0]) * 64'(sc_s74[31:0]);
			pl1_s75 <= 64'(p_q[31:0]) * 64'(sc_s74[63:32]);
			pl2_s75 <= (L2_W + 32)'(p_q[31:0]) * (L2_W + 32)'(sc_s74[SC_W-1:64]);
			ph0_s75 <= (PH_W + 32)'(p_q[P_W-1:32]) * (PH_W + 32)'(sc_s74[31:0]);
			ph1_s75 <= (PH_W + 32)'(p_q[P_W-1:32]) * (PH_W + 32)'(sc_s74[63:32]);
			ph2_s75 <= (PH_W + L2_W)'(p_q[P_W-1:32]) * (PH_W + L2_W)'(sc_s74[SC_W-1:64]);
			rlo_s76 <= (SC_W + 32)'(pl0_s75) + ((SC_W + 32)'(pl1_s75) << 32)
				+ ((SC_W + 32)'(pl2_s75) << 64);
			rhi_s76 <= (SC_W + PH_W)'(ph0_s75) + ((SC_W + PH_W)'(ph1_s75) << 32)
				+ ((SC_W + PH_W)'(ph2_s75) << 64);
			num_s77 <= N_W'(rlo_s76) + (N_W'(rhi_s76) << 32);
		end
	end

	// rounding and saturation
	logic [NN_W-1:0] num2_s78;
	logic [DD_W-1:0] den2_s78;

	always_ff @(posedge clk) begin
		if (en) begin
			num2_s78 <= (NN_W'(num_s77) << 1) + NN_W'(den_s[ST_NUM]);
			den2_s78 <= {den_s[ST_NUM], 1'b0};
		end
	end

	assign sat_c = CMP_W'(num2_s78) >= (CMP_W'(den2_s78) << 32);

	// final quotient, one bit per stage
	logic [DD_W-1:0] qr_s [0:31];
	logic [31:0] qlo_s [0:31];
	logic [DD_W-1:0] qd_s [0:31];
	logic [31:0] qq_s [0:32];

	always_ff @(posedge clk) begin
		if (en) begin
			qr_s[0] <= DD_W'(num2_s78 >> 32);
			qlo_s[0] <= num2_s78[31:0];
			qd_s[0] <= den2_s78;
			qq_s[0] <= '0;
		end
	end

	for (genvar j = 1; j <= 32; j++) begin : g_q
		logic [DD_W:0] rr;
		logic ge;
		assign rr = {qr_s[j-1], qlo_s[j-1][31]};
		assign ge = rr >= {1'b0, qd_s[j-1]};
		always_ff @(posedge clk) begin
			if (en) qq_s[j] <= {qq_s[j-1][30:0], ge};
		end
		if (j < 32) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					qr_s[j] <= ge ? DD_W'(rr - {1'b0, qd_s[j-1]}) : DD_W'(rr);
					qlo_s[j] <= {qlo_s[j-1][30:0], 1'b0};
					qd_s[j] <= qd_s[j-1];
				end
			end
		end
	end

	// result register
	bbel_pkg::result_t res_s;

	always_ff @(posedge clk) begin
		if (en) begin
			if (fl_s[NS-1].zro) begin
				res_s <= '{energy_loss: '0, status: bbel_pkg::ST_ZERO};
			end else if (fl_s[NS-1].neg) begin
				res_s <= '{energy_loss: '0, status: bbel_pkg::ST_NEG};
			end else if (fl_s[NS-1].sat) begin
				res_s <= '{energy_loss: '1, status: bbel_pkg::ST_SAT};
			end else begin
				res_s <= '{energy_loss: qq_s[32], status: bbel_pkg::ST_OK};
			end
		end
	end

	assign result_valid = fl_s[NS].vld;
	assign result = res_s;

endmodule

// File: tb/sv/bethe_bloch_energy_loss_checker.sv
`timescale 1ns / 1ps
// Energy loss predictor and result scoreboard for the Bethe-Bloch pipeline.
module bethe_bloch_energy_loss_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  logic                         item_stall,
	input  bbel_pkg::item_t              item,
	input  logic                         result_valid,
	input  logic                         result_stall,
	input  bbel_pkg::result_t            result,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [bbel_pkg::CFG_W-1:0]   cfg_data,
	output int                           fail_count,
	output int                           pending,
	output int                           beats_checked
);
	logic [15:0] exc_q;
	logic [15:0] zoa_q;
	logic [23:0] rho_q;
	logic [3:0]  chg_q;
	bbel_pkg::result_t loss_queue[$];

	function automatic longint ln_fixed(input logic [63:0] x);
		int          e;
		logic [63:0] m;
		logic [63:0] frac;
		logic [63:0] l2;
		logic [127:0] sq;
		logic [127:0] pr;
		e = 0;
		for (int i = 0; i < 64; i++)
			if (x[i]) e = i;
		m = x << (63 - e);
		frac = '0;
		for (int i = 0; i < 32; i++) begin
			sq = {64'd0, m} * {64'd0, m};
			frac = {frac[62:0], sq[127]};
			m = sq[127] ? sq[127:64] : sq[126:63];
		end
		l2 = (64'(e) << 32) | frac;
		pr = {64'd0, l2} * {64'd0, 64'hB17217F7D1CF79AB};
		return longint'(pr[127:64]);
	endfunction

	function automatic bbel_pkg::result_t predict_loss(input bbel_pkg::item_t it);
		bbel_pkg::result_t r;
		logic [255:0] t, mm, a, tm2, msq, dt, b2, num, den;
		longint       lnarg, s;
		t = 256'(it.kinetic_energy);
		mm = 256'(it.particle_mass);
		if (t == 0 || mm == 0) begin
			r.energy_loss = '0;
			r.status = bbel_pkg::ST_ZERO;
			return r;
		end
		a = t * (t + 2 * mm);
		tm2 = (t + mm) * (t + mm);
		msq = mm * mm;
		dt = (mm + 511) * (mm + 511) + 1022 * t;
		lnarg = ln_fixed(64'd104448400000000) + 2 * ln_fixed(a[63:0])
			- ln_fixed(msq[63:0]) - ln_fixed(dt[63:0])
			- 2 * ln_fixed(64'(exc_q == 0 ? 16'd1 : exc_q));
		b2 = (a << 32) / tm2;
		s = lnarg - 2 * longint'(b2[63:0]);
		if (s < 0) begin
			r.energy_loss = '0;
			r.status = bbel_pkg::ST_NEG;
			return r;
		end
		num = 256'(307075) * 256'(chg_q) * 256'(chg_q) * 256'(zoa_q) * 256'(rho_q)
			* 256'(s) * tm2;
		den = a * 256'(64'd131072000000);
		num = 2 * num + den;
		den = 2 * den;
		if (num >= (den << 32)) begin
			r.energy_loss = 32'hFFFF_FFFF;
			r.status = bbel_pkg::ST_SAT;
		end else begin
			b2 = num / den;
			r.energy_loss = b2[31:0];
			r.status = bbel_pkg::ST_OK;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bbel_pkg::result_t want;
		logic    bad;
		if (!arst_n) begin
			exc_q <= 16'd1674;
			zoa_q <= 16'd30147;
			rho_q <= 24'd1773;
			chg_q <= 4'd1;
			fail_count <= 0;
			beats_checked <= 0;
			loss_queue.delete();
		end else begin
			if (item_valid && !item_stall)
				loss_queue.push_back(predict_loss(item));
			if (result_valid && !result_stall) begin
				beats_checked <= beats_checked + 1;
				if (loss_queue.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result beat: loss %0d status %0d",
							result.energy_loss, result.status);
					fail_count <= fail_count + 1;
				end else begin
					want = loss_queue.pop_front();
					// one LSB of rounding slack on a normal result
					bad = (want.status != result.status);
					if (want.status == bbel_pkg::ST_OK) begin
						if (want.energy_loss > result.energy_loss)
							bad |= (want.energy_loss - result.energy_loss) > 1;
						else
							bad |= (result.energy_loss - want.energy_loss) > 1;
					end else begin
						bad |= (want.energy_loss != result.energy_loss);
					end
					if (bad) begin
						if (fail_count < 10)
							$display("mismatch: loss exp %0d got %0d, status exp %0d got %0d",
								want.energy_loss, result.energy_loss, want.status,
								result.status);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					bbel_pkg::REG_EXC: exc_q <= cfg_data[15:0];
					bbel_pkg::REG_ZOA: zoa_q <= cfg_data[15:0];
					bbel_pkg::REG_RHO: rho_q <= cfg_data[23:0];
					bbel_pkg::REG_CHG: chg_q <= cfg_data[3:0];
					default: ;
				endcase
			end
		end
	end

	assign pending = loss_queue.size();

endmodule

// File: tb/sv/bethe_bloch_energy_loss_tb.sv
`timescale 1ns / 1ps
// Stimulus, configuration phases and verdict for the Bethe-Bloch energy loss pipeline.
module bethe_bloch_energy_loss_tb;
	localparam int WATCHDOG_LIMIT = 3000;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	bbel_pkg::item_t   item;
	logic              result_valid;
	logic              result_stall;
	bbel_pkg::result_t result;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [bbel_pkg::CFG_W-1:0] cfg_data;
	int                fail_count;
	int                pending;
	int                beats_checked;
	int                idle_cycles;
	int                items_sent;
	bit                quiet;

	bethe_bloch_energy_loss DUT (.*);

	bethe_bloch_energy_loss_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side stalls in bursts
	always @(negedge clk) begin
		if (!quiet && $urandom_range(0, 7) == 0) begin
			result_stall = 1'b1;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		result_stall = 1'b0;
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_beat(input logic [23:0] ke, input logic [23:0] pm);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		item.kinetic_energy = ke;
		item.particle_mass = pm;
		item_valid = 1'b1;
		do @(posedge clk); while (item_stall);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [bbel_pkg::CFG_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain;
		item_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	function automatic logic [23:0] rand_energy();
		case ($urandom_range(0, 3))
			0: return 24'($urandom);
			1: return 24'($urandom_range(1, 5000));
			default: return 24'($urandom) & ((24'd1 << $urandom_range(1, 24)) - 1);
		endcase
	endfunction

	task automatic random_items(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 2) == 0)
				send_beat(rand_energy(), 24'(938272 + $urandom_range(0, 3000) - 1500));
			else
				send_beat(rand_energy(), rand_energy());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bbel_pkg::REG_EXC;
		cfg_data = '0;
		quiet = 1'b0;
		items_sent = 0;
		idle_cycles = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_beat(24'd0, 24'd938272);
		send_beat(24'd1000, 24'd0);
		send_beat(24'd0, 24'd0);
		send_beat(24'hFFFFFF, 24'hFFFFFF);
		send_beat(24'd1, 24'd1);
		send_beat(24'd1, 24'hFFFFFF);
		send_beat(24'hFFFFFF, 24'd1);
		send_beat(24'd1000, 24'd938272);
		send_beat(24'd100000, 24'd938272);
		send_beat(24'd5000000, 24'd938272);
		send_beat(24'd1, 24'd938272);
		send_beat(24'd1000, 24'd511);
		send_beat(24'd3727379, 24'd3727379);
		send_beat(24'h555555, 24'hAAAAAA);
		send_beat(24'hAAAAAA, 24'h555555);
		random_items(200);
		drain();

		write_reg(bbel_pkg::REG_EXC, 24'd1);
		write_reg(bbel_pkg::REG_ZOA, 24'd65535);
		write_reg(bbel_pkg::REG_RHO, 24'hFFFFFF);
		write_reg(bbel_pkg::REG_CHG, 24'd15);
		send_beat(24'd1, 24'hFFFFFF);
		send_beat(24'd100, 24'd938272);
		random_items(170);
		drain();

		write_reg(bbel_pkg::REG_EXC, 24'd65535);
		write_reg(bbel_pkg::REG_ZOA, 24'd1);
		write_reg(bbel_pkg::REG_RHO, 24'd1);
		write_reg(bbel_pkg::REG_CHG, 24'd1);
		random_items(170);
		drain();

		write_reg(bbel_pkg::REG_EXC, 24'd0);
		write_reg(bbel_pkg::REG_ZOA, 24'd0);
		write_reg(bbel_pkg::REG_RHO, 24'd0);
		write_reg(bbel_pkg::REG_CHG, 24'd0);
		random_items(60);
		drain();

		write_reg(bbel_pkg::REG_EXC, 24'($urandom_range(1, 65535)));
		write_reg(bbel_pkg::REG_ZOA, 24'($urandom_range(1, 65535)));
		write_reg(bbel_pkg::REG_RHO, 24'($urandom));
		write_reg(bbel_pkg::REG_CHG, 24'($urandom_range(1, 15)));
		random_items(150);

		quiet = 1'b1;
		random_items(150);
		drain();

		$display("covered %0d item beats, %0d results checked, over five gas settings",
			items_sent, beats_checked);
		$display("settings spanned register extremes, zero registers and random gases");
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
